### rtl/lsrc_pkg.sv
// Shared types, constants and the divider step function for the segment clipper.
// No dependencies; every other rtl file imports this package.
`timescale 1ns / 1ps
package lsrc_pkg;

  // coordinate and parameter formats
  localparam int CW     = 16;          // coordinate width, signed Q12.4
  localparam int TF     = 16;          // fraction bits of the t parameter
  localparam int TW     = TF + 2;      // signed t, range -1 .. ONE+1
  localparam int PW     = CW + TW + 1; // delta times t product width
  localparam int NSTEP  = TF + 2;      // divider steps: TF+1 quotient bits, one round
  localparam int SPS    = 3;           // divider steps per pipeline stage
  localparam int DSTG   = (NSTEP + SPS - 1) / SPS;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [CW:0]   delta_t;
  typedef logic signed [TW-1:0] tpar_t;
  typedef logic signed [PW-1:0] prod_t;

  localparam tpar_t T_ONE  = tpar_t'(1) <<< TF;
  localparam tpar_t T_SAT  = T_ONE + tpar_t'(1);
  localparam tpar_t T_NEG1 = '1;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_MIN_X = 2'd0,
    CFG_MAX_X = 2'd1,
    CFG_MIN_Y = 2'd2,
    CFG_MAX_Y = 2'd3
  } cfg_idx_t;

  // one quotient request: |n| / den with sign and overflow flags
  typedef struct packed {
    logic [CW-1:0] mag;
    logic [CW-1:0] den;
    logic          neg;
    logic          sat;
  } div_req_t;

  // divider working state carried between stages
  typedef struct packed {
    logic [CW:0]   rem;
    logic [TF+1:0] q;
    logic [CW-1:0] den;
    logic          neg;
    logic          sat;
  } div_st_t;

  typedef struct packed {
    coord_t p;
    delta_t d;
    logic   zero;  // delta is zero, axis does not narrow t
  } axis_t;

  // per-item side data that rides alongside the dividers
  typedef struct packed {
    axis_t ax;
    axis_t ay;
    logic  rej;
  } side_t;

  // one restoring step; step 0 has no shift, the last step rounds half up
  function automatic div_st_t div_step(div_st_t s, int j);
    div_st_t       o;
    logic [CW+1:0] rs;
    logic          bit_q;
    o = s;
    if (j <= TF) begin
      rs = (j == 0) ? {1'b0, s.rem} : {s.rem, 1'b0};
      bit_q = (rs >= {2'b00, s.den});
      if (bit_q) begin
        rs = rs - {2'b00, s.den};
      end
      o.rem = rs[CW:0];
      o.q = {s.q[TF:0], bit_q};
    end else if (j == TF + 1) begin
      if ({s.rem, 1'b0} >= {2'b00, s.den}) begin
        o.q = s.q + {{(TF+1){1'b0}}, 1'b1};
      end
    end
    return o;
  endfunction

endpackage

### rtl/lsrc_prep.sv
// Input stage: deltas, entry/exit numerators and zero-delta rejects per axis.
// Depends on lsrc_pkg.
`timescale 1ns / 1ps
module lsrc_prep (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_acc,
  input  lsrc_pkg::coord_t  start_x,
  input  lsrc_pkg::coord_t  start_y,
  input  lsrc_pkg::coord_t  end_x,
  input  lsrc_pkg::coord_t  end_y,
  input  lsrc_pkg::coord_t  min_x,
  input  lsrc_pkg::coord_t  max_x,
  input  lsrc_pkg::coord_t  min_y,
  input  lsrc_pkg::coord_t  max_y,
  output logic              vld_r,
  output lsrc_pkg::side_t   side_r,
  output lsrc_pkg::div_req_t ex_r,
  output lsrc_pkg::div_req_t xx_r,
  output lsrc_pkg::div_req_t ey_r,
  output lsrc_pkg::div_req_t xy_r
);
  import lsrc_pkg::*;

  typedef struct packed {
    axis_t    ax;
    div_req_t ent;
    div_req_t ext;
    logic     out;
  } prep_t;

  function automatic div_req_t mk_req(delta_t n, logic [CW-1:0] den);
    div_req_t   r;
    logic [CW:0] m;
    m = n[CW] ? (-n) : n;
    r.mag = m[CW-1:0];
    r.den = den;
    r.neg = n[CW];
    r.sat = (m >= {den, 1'b0});
    return r;
  endfunction

  function automatic prep_t axis_prep(coord_t s, coord_t e, coord_t lo, coord_t hi);
    prep_t  o;
    delta_t d, ne, nx, dn;
    d = delta_t'(e) - delta_t'(s);
    if (d > 0) begin
      ne = delta_t'(lo) - delta_t'(s);
      nx = delta_t'(hi) - delta_t'(s);
      dn = d;
    end else begin
      ne = delta_t'(s) - delta_t'(hi);
      nx = delta_t'(s) - delta_t'(lo);
      dn = -d;
    end
    o.ax.p = s;
    o.ax.d = d;
    o.ax.zero = (d == '0);
    o.ent = mk_req(ne, dn[CW-1:0]);
    o.ext = mk_req(nx, dn[CW-1:0]);
    o.out = (s < lo) || (s > hi);
    return o;
  endfunction

  prep_t px, py;

  always_comb begin
    px = axis_prep(start_x, end_x, min_x, max_x);
    py = axis_prep(start_y, end_y, min_y, max_y);
  end

  // valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_acc;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      side_r.ax  <= px.ax;
      side_r.ay  <= py.ax;
      side_r.rej <= (px.ax.zero && px.out) || (py.ax.zero && py.out);
      ex_r <= px.ent;
      xx_r <= px.ext;
      ey_r <= py.ent;
      xy_r <= py.ext;
    end
  end

endmodule

### rtl/lsrc_div.sv
// Pipelined restoring divider: round(|n| * 2^TF / den), clamped to -1 .. ONE+1.
// Depends on lsrc_pkg.
`timescale 1ns / 1ps
module lsrc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               req_vld,
  input  lsrc_pkg::div_req_t req,
  output logic               t_vld,
  output lsrc_pkg::tpar_t    t
);
  import lsrc_pkg::*;

  div_st_t st_r  [DSTG];
  div_st_t st_nxt[DSTG];
  logic    vld_r [DSTG];

  // step logic, SPS steps per stage
  for (genvar s = 0; s < DSTG; s++) begin : g_stg
    div_st_t w_in;
    logic    v_in;

    if (s == 0) begin : g_first
      assign w_in = '{rem: {1'b0, req.mag}, q: '0, den: req.den,
                      neg: req.neg, sat: req.sat};
      assign v_in = req_vld;
    end else begin : g_next
      assign w_in = st_r[s-1];
      assign v_in = vld_r[s-1];
    end

    always_comb begin
      div_st_t w;
      w = w_in;
      for (int k = 0; k < SPS; k++) begin
        w = div_step(w, s * SPS + k);
      end
      st_nxt[s] = w;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[s] <= st_nxt[s];
      end
    end
  end

  // final clamp; a negative numerator always maps to -1
  always_comb begin
    div_st_t f;
    f = st_r[DSTG-1];
    if (f.neg) begin
      t = T_NEG1;
    end else if (f.sat || (tpar_t'(f.q) > T_SAT)) begin
      t = T_SAT;
    end else begin
      t = tpar_t'(f.q);
    end
  end

  assign t_vld = vld_r[DSTG-1];

endmodule

### rtl/lsrc_interp.sv
// Back end: interval narrowing, delta*t products and rounded endpoints.
// Three register stages, the last is the output register. Depends on lsrc_pkg.
`timescale 1ns / 1ps
module lsrc_interp (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             vld,
  input  lsrc_pkg::side_t  side,
  input  lsrc_pkg::tpar_t  ex,
  input  lsrc_pkg::tpar_t  xx,
  input  lsrc_pkg::tpar_t  ey,
  input  lsrc_pkg::tpar_t  xy,
  output logic             out_vld_r,
  output logic             vis_r,
  output lsrc_pkg::coord_t sx_r,
  output lsrc_pkg::coord_t sy_r,
  output lsrc_pkg::coord_t ex_r,
  output lsrc_pkg::coord_t ey_r
);
  import lsrc_pkg::*;

  // narrowing stage
  logic          c_vld_r, c_rej_r;
  side_t         c_side_r;
  logic [TF:0]   t1_r, t2_r;
  tpar_t         t1, t2;

  always_comb begin
    t1 = '0;
    t2 = T_ONE;
    if (!side.ax.zero) begin
      if (ex > t1) t1 = ex;
      if (xx < t2) t2 = xx;
    end
    if (!side.ay.zero) begin
      if (ey > t1) t1 = ey;
      if (xy < t2) t2 = xy;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (en) begin
      c_vld_r <= vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_rej_r  <= side.rej || (t1 > t2);
      c_side_r <= side;
      t1_r     <= t1[TF:0];
      t2_r     <= t2[TF:0];
    end
  end

  // product stage
  logic  m_vld_r, m_rej_r;
  side_t m_side_r;
  prod_t psx_r, psy_r, pex_r, pey_r;

  function automatic prod_t mul(delta_t d, logic [TF:0] t);
    return prod_t'(d) * prod_t'($signed({1'b0, t}));
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (en) begin
      m_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_rej_r  <= c_rej_r;
      m_side_r <= c_side_r;
      psx_r    <= mul(c_side_r.ax.d, t1_r);
      psy_r    <= mul(c_side_r.ay.d, t1_r);
      pex_r    <= mul(c_side_r.ax.d, t2_r);
      pey_r    <= mul(c_side_r.ay.d, t2_r);
    end
  end

  // rounding stage, halves away from zero
  function automatic coord_t lerp(coord_t p, prod_t prod);
    logic [PW-1:0] mag, r, sum;
    mag = prod[PW-1] ? (-prod) : prod;
    r   = (mag + (PW'(1) << (TF - 1))) >> TF;
    sum = prod[PW-1] ? (PW'(p) - r) : (PW'(p) + r);
    return coord_t'(sum[CW-1:0]);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vis_r <= !m_rej_r;
      sx_r  <= m_rej_r ? '0 : lerp(m_side_r.ax.p, psx_r);
      sy_r  <= m_rej_r ? '0 : lerp(m_side_r.ay.p, psy_r);
      ex_r  <= m_rej_r ? '0 : lerp(m_side_r.ax.p, pex_r);
      ey_r  <= m_rej_r ? '0 : lerp(m_side_r.ay.p, pey_r);
    end
  end

endmodule

### rtl/line_segment_rect_clip_unit.sv
// Segment clipper against a rectangular window (Liang-Barsky), top level.
// Depends on lsrc_pkg, lsrc_prep, lsrc_div and lsrc_interp.
//
// Usage:
//  - Input channel in_*: one segment (start/end point, signed Q12.4) per item.
//  - Output channel out_*: one result per item: visible flag and clipped
//    endpoints, rounded to nearest; all zero when the segment is rejected.
//  - Config channel cfg_*: writes the window edges (min x, max x, min y,
//    max y); cfg_ready is always high. Write only while the pipe is empty.
//  - Between accept and output valid lie the input register, the DSTG
//    divider stages and the back end's narrowing, product and output
//    registers; the four divider pipes make up most of this (three divider steps per stage).
//  - Throughput: one item per cycle while the output is not stalled.
//  - All stages share one advance enable: when out_valid is high and
//    out_ready is low the whole pipe holds and in_ready drops; nothing is
//    lost or repeated.
//  - Reset clears all valid bits and sets the window to the full range.
`timescale 1ns / 1ps
module line_segment_rect_clip_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lsrc_pkg::coord_t    in_start_x,
  input  lsrc_pkg::coord_t    in_start_y,
  input  lsrc_pkg::coord_t    in_end_x,
  input  lsrc_pkg::coord_t    in_end_y,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_visible,
  output lsrc_pkg::coord_t    out_clip_start_x,
  output lsrc_pkg::coord_t    out_clip_start_y,
  output lsrc_pkg::coord_t    out_clip_end_x,
  output lsrc_pkg::coord_t    out_clip_end_y,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  lsrc_pkg::cfg_idx_t  cfg_index,
  input  lsrc_pkg::coord_t    cfg_wdata
);
  import lsrc_pkg::*;

  logic   en;
  coord_t min_x_r, max_x_r, min_y_r, max_y_r;

  // global advance
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  // window registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_x_r <= {1'b1, {(CW-1){1'b0}}};
      max_x_r <= {1'b0, {(CW-1){1'b1}}};
      min_y_r <= {1'b1, {(CW-1){1'b0}}};
      max_y_r <= {1'b0, {(CW-1){1'b1}}};
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MIN_X: min_x_r <= cfg_wdata;
        CFG_MAX_X: max_x_r <= cfg_wdata;
        CFG_MIN_Y: min_y_r <= cfg_wdata;
        CFG_MAX_Y: max_y_r <= cfg_wdata;
      endcase
    end
  end

  // input stage
  logic     p_vld;
  side_t    p_side;
  div_req_t q_ex, q_xx, q_ey, q_xy;

  lsrc_prep u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_acc  (in_valid && in_ready),
    .start_x (in_start_x),
    .start_y (in_start_y),
    .end_x   (in_end_x),
    .end_y   (in_end_y),
    .min_x   (min_x_r),
    .max_x   (max_x_r),
    .min_y   (min_y_r),
    .max_y   (max_y_r),
    .vld_r   (p_vld),
    .side_r  (p_side),
    .ex_r    (q_ex),
    .xx_r    (q_xx),
    .ey_r    (q_ey),
    .xy_r    (q_xy)
  );

  // four quotient pipes
  logic  d_vld;
  logic  d_vld_xx, d_vld_ey, d_vld_xy;
  tpar_t t_ex, t_xx, t_ey, t_xy;

  lsrc_div u_div_ex (.clk(clk), .rst_n(rst_n), .en(en), .req_vld(p_vld), .req(q_ex),
                     .t_vld(d_vld), .t(t_ex));
  lsrc_div u_div_xx (.clk(clk), .rst_n(rst_n), .en(en), .req_vld(p_vld), .req(q_xx),
                     .t_vld(d_vld_xx), .t(t_xx));
  lsrc_div u_div_ey (.clk(clk), .rst_n(rst_n), .en(en), .req_vld(p_vld), .req(q_ey),
                     .t_vld(d_vld_ey), .t(t_ey));
  lsrc_div u_div_xy (.clk(clk), .rst_n(rst_n), .en(en), .req_vld(p_vld), .req(q_xy),
                     .t_vld(d_vld_xy), .t(t_xy));

  // side data delay matching the divider depth
  side_t side_r [DSTG];

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= p_side;
      for (int i = 1; i < DSTG; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // back end with output register
  lsrc_interp u_interp (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .vld       (d_vld),
    .side      (side_r[DSTG-1]),
    .ex        (t_ex),
    .xx        (t_xx),
    .ey        (t_ey),
    .xy        (t_xy),
    .out_vld_r (out_valid),
    .vis_r     (out_visible),
    .sx_r      (out_clip_start_x),
    .sy_r      (out_clip_start_y),
    .ex_r      (out_clip_end_x),
    .ey_r      (out_clip_end_y)
  );

  // checks
  a_div_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (d_vld == d_vld_xx) && (d_vld == d_vld_ey) && (d_vld == d_vld_xy))
    else $error("divider pipes out of step");

  a_rej_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_visible |-> (out_clip_start_x == '0) && (out_clip_start_y == '0)
      && (out_clip_end_x == '0) && (out_clip_end_y == '0))
    else $error("rejected item has nonzero coordinates");

  a_cfg_wr: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && (cfg_index == CFG_MIN_X) |=> (min_x_r == $past(cfg_wdata)))
    else $error("window write lost");

  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

endmodule

### test/line_segment_rect_clip_unit_tb.sv
// Testbench for line_segment_rect_clip_unit: random and directed segments are
// clipped by an in-bench Liang-Barsky predictor and compared per result field.
// Depends on lsrc_pkg and the clipper RTL.
`timescale 1ns / 1ps
module line_segment_rect_clip_unit_tb;
  import lsrc_pkg::*;

  typedef struct {
    coord_t sx, sy, ex, ey;
  } seg_t;

  typedef struct {
    logic   vis;
    coord_t csx, csy, cex, cey;
  } clip_t;

  localparam longint TONE = 64'sd1 << TF;
  localparam int HOLD_CYCLES = 200;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_ready;
  coord_t in_start_x = '0, in_start_y = '0, in_end_x = '0, in_end_y = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  logic   out_visible;
  coord_t out_clip_start_x, out_clip_start_y, out_clip_end_x, out_clip_end_y;
  logic   cfg_valid = 1'b0;
  logic   cfg_ready;
  cfg_idx_t cfg_index = CFG_MIN_X;
  coord_t cfg_wdata = '0;

  line_segment_rect_clip_unit dut (.*);

  always #5 clk = ~clk;

  // window copy used by the predictor
  longint wmin_x, wmax_x, wmin_y, wmax_y;

  seg_t   pending_segs[$];
  clip_t  expected_clips[$];
  int     n_errors = 0;
  bit     hold_off = 1'b0;
  bit     feeding = 1'b1;
  bit     in_taken = 1'b0;

  // rounded quotient n*ONE/d, d > 0, saturated to [-1, ONE+1]
  function automatic longint t_quot(longint n, longint d);
    longint mag, q;
    mag = (n < 0) ? -n : n;
    q = ((mag << (TF + 1)) + d) / (2 * d);
    if (q > TONE + 1) q = TONE + 1;
    q = (n < 0) ? -q : q;
    if (q < -1) q = -1;
    return q;
  endfunction

  function automatic longint lerp_coord(longint p, longint d, longint t);
    longint prod, mag, r;
    prod = d * t;
    mag = (prod < 0) ? -prod : prod;
    r = (mag + (64'sd1 << (TF - 1))) >>> TF;
    return (prod < 0) ? p - r : p + r;
  endfunction

  // narrow [t1,t2] on one axis; returns 1 on rejection
  function automatic bit narrow_axis(longint p, longint d, longint lo, longint hi,
                                     inout longint t1, inout longint t2);
    longint e, x;
    if (d == 0) return (p < lo) || (p > hi);
    if (d > 0) begin
      e = t_quot(lo - p, d);
      x = t_quot(hi - p, d);
    end else begin
      e = t_quot(p - hi, -d);
      x = t_quot(p - lo, -d);
    end
    if (e > t1) t1 = e;
    if (x < t2) t2 = x;
    return 1'b0;
  endfunction

  function automatic clip_t clip_segment(seg_t s);
    clip_t  c;
    longint px, py, dx, dy, t1, t2;
    bit     rej;
    px = s.sx; py = s.sy;
    dx = longint'(s.ex) - px;
    dy = longint'(s.ey) - py;
    t1 = 0; t2 = TONE;
    rej = narrow_axis(px, dx, wmin_x, wmax_x, t1, t2);
    if (narrow_axis(py, dy, wmin_y, wmax_y, t1, t2)) rej = 1'b1;
    if (t1 > t2) rej = 1'b1;
    c = '{1'b0, '0, '0, '0, '0};
    if (!rej) begin
      c.vis = 1'b1;
      c.csx = coord_t'(lerp_coord(px, dx, t1));
      c.csy = coord_t'(lerp_coord(py, dy, t1));
      c.cex = coord_t'(lerp_coord(px, dx, t2));
      c.cey = coord_t'(lerp_coord(py, dy, t2));
    end
    return c;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
    n_errors++;
  endtask

  // input accept seen at the rising edge
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && in_ready;
  end

  // sender: bursts with random gaps
  int burst_left = 0, gap_left = 0;
  always @(negedge clk) begin
    if (in_taken) begin
      expected_clips = {expected_clips, clip_segment(pending_segs.pop_front())};
    end
    if (!rst_n || (in_valid && !in_taken)) begin
      // hold the offered item
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid <= 1'b0;
    end else if (pending_segs.size() > 0 && feeding) begin
      in_valid <= 1'b1;
      in_start_x <= pending_segs[0].sx;
      in_start_y <= pending_segs[0].sy;
      in_end_x <= pending_segs[0].ex;
      in_end_y <= pending_segs[0].ey;
      if (burst_left > 0) burst_left--;
      else begin
        burst_left = $urandom_range(0, 20);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 4);
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver: own stall pattern, plus a long hold-off counted here
  int stall_mode = 0;
  int hold_cnt = 0;
  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
    if (hold_off && hold_cnt < HOLD_CYCLES) begin
      hold_cnt++;
      out_ready <= 1'b0;
    end else case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // result checker
  always @(posedge clk) begin
    clip_t w;
    if (rst_n && out_valid && out_ready) begin
      if (expected_clips.size() == 0) begin
        report_mismatch("unexpected result, visible", out_visible, -1);
      end else begin
        w = expected_clips.pop_front();
        if (out_visible !== w.vis) report_mismatch("visible", out_visible, w.vis);
        if (out_clip_start_x !== w.csx)
          report_mismatch("clip_start_x", out_clip_start_x, w.csx);
        if (out_clip_start_y !== w.csy)
          report_mismatch("clip_start_y", out_clip_start_y, w.csy);
        if (out_clip_end_x !== w.cex)
          report_mismatch("clip_end_x", out_clip_end_x, w.cex);
        if (out_clip_end_y !== w.cey)
          report_mismatch("clip_end_y", out_clip_end_y, w.cey);
      end
    end
  end

  task automatic add_seg(int sx, int sy, int ex, int ey);
    seg_t s;
    s.sx = coord_t'(sx); s.sy = coord_t'(sy);
    s.ex = coord_t'(ex); s.ey = coord_t'(ey);
    pending_segs = {pending_segs, s};
  endtask

  // wait for the pipe to empty, then let its latency pass
  task automatic drain();
    while (pending_segs.size() > 0 || in_valid || expected_clips.size() > 0)
      @(posedge clk);
    repeat (15) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, int val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= coord_t'(val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_MIN_X: wmin_x = coord_t'(val);
      CFG_MAX_X: wmax_x = coord_t'(val);
      CFG_MIN_Y: wmin_y = coord_t'(val);
      default:   wmax_y = coord_t'(val);
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_window(int x0, int x1, int y0, int y1);
    write_reg(CFG_MIN_X, x0);
    write_reg(CFG_MAX_X, x1);
    write_reg(CFG_MIN_Y, y0);
    write_reg(CFG_MAX_Y, y1);
  endtask

  function automatic int rand_coord(int lo, int hi);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return -32768;
    if (r == 1) return 32767;
    if (r < 4) return int'($urandom_range(0, 65535)) - 32768;
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  task automatic random_phase(int n, int lo, int hi);
    repeat (n) add_seg(rand_coord(lo, hi), rand_coord(lo, hi),
                       rand_coord(lo, hi), rand_coord(lo, hi));
  endtask

  // stimulus
  initial begin
    wmin_x = -32768; wmax_x = 32767; wmin_y = -32768; wmax_y = 32767;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // full window after reset: extremes pass untouched
    add_seg(-32768, -32768, 32767, 32767);
    add_seg(32767, -32768, -32768, 32767);
    add_seg(0, 0, 0, 0);
    drain();

    set_window(-1600, 1600, -800, 800);
    add_seg(-3200, 0, 3200, 0);        // zero dy, inside in y
    add_seg(-3200, 900, 3200, 900);    // zero dy, outside in y
    add_seg(100, -3200, 100, 3200);    // zero dx, inside
    add_seg(2000, -3200, 2000, 3200);  // zero dx, outside
    add_seg(0, 0, 0, 0);               // degenerate inside
    add_seg(5000, 5000, 5000, 5000);   // degenerate outside
    add_seg(-3200, -3200, 3200, 3200); // diagonal through
    add_seg(3200, 3200, -3200, -3200); // reversed
    add_seg(1600, 800, 3000, 2000);    // touches corner
    add_seg(-3000, 2000, 3000, 2100);  // misses, empty interval
    add_seg(-32768, -32768, 32767, 32767);
    add_seg(10, 20, 30, 40);           // fully inside
    add_seg(-1700, 700, -1500, 900);   // near corner
    drain();

    set_window(100, -100, -32768, 32767); // inverted x
    add_seg(-500, 0, 500, 0);
    add_seg(0, -500, 0, 500);
    add_seg(-32768, 5, 32767, -5);
    drain();

    // long receiver hold-off while items keep coming
    set_window(-4000, 4000, -4000, 4000);
    hold_off = 1'b1;
    random_phase(100, -8000, 8000);
    wait (hold_cnt == HOLD_CYCLES);
    hold_off = 1'b0;
    drain();

    random_phase(300, -8000, 8000);
    drain();
    set_window(-32768, 32767, -32768, 32767);
    random_phase(200, -32768, 32767);
    drain();
    set_window(32767, 32767, -32768, -32768);
    random_phase(100, -32768, 32767);
    drain();
    set_window(-20, 30, -50, 10);
    random_phase(300, -200, 200);
    drain();

    if (n_errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule

### line_segment_rect_clip_unit.f
rtl/lsrc_pkg.sv
rtl/lsrc_prep.sv
rtl/lsrc_div.sv
rtl/lsrc_interp.sv
rtl/line_segment_rect_clip_unit.sv
test/line_segment_rect_clip_unit_tb.sv
